### rtl/zchng_pkg.sv
// Package for the zero-crossing-hold noise gate.
// Holds the shared widths, register reset values and indexes, the shape coefficients
// and the gate command and status types. It depends on nothing.
package zchng_pkg;

  localparam int SAMPLE_WIDTH_DEF        = 24;
  localparam int COUNT_LIMIT_DEF         = 6000;
  localparam int LEVEL_FRACTION_BITS_DEF = 16;

  localparam int GATE_BITS   = 16;
  localparam int THR_W       = 23;
  localparam int REL_W       = 16;
  localparam int WET_W       = 17;
  localparam int CFG_DATA_W  = 23;
  localparam int CFG_INDEX_W = 2;
  localparam int COEF_W      = 30;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 23'd1510;
  localparam logic [REL_W-1:0] RELEASE_RESET   = 16'd419;
  localparam logic [WET_W-1:0] WET_RESET       = 17'd65536;
  localparam logic [WET_W-1:0] MIX_ONE         = 17'd65536;
  localparam logic [GATE_BITS:0] GATE_ONE      = (GATE_BITS + 1)'(1) << GATE_BITS;

  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WET       = 2'd2;

  typedef struct packed {
    logic upd;
    logic ch;
    logic x_pos;
    logic above;
  } gate_cmd_t;

  typedef struct packed {
    logic [GATE_BITS:0] g;
    logic               closed;
  } gate_stat_t;

  // Horner coefficients of 1 - cos(t) in Q30, highest order first.
  function automatic logic [COEF_W-1:0] shape_coef(input logic [2:0] idx);
    logic [COEF_W-1:0] c;
    case (idx)
      3'd0:    c = 30'd296;
      3'd1:    c = 30'd26631;
      3'd2:    c = 30'd1491308;
      3'd3:    c = 30'd44739243;
      3'd4:    c = 30'd536870912;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

### rtl/zchng_mul.sv
// Shared signed multiplier of the noise gate, with a registered product.
// Depends on zchng_pkg for its default operand width.
module zchng_mul import zchng_pkg::*; #(
  parameter int OP_WIDTH = COEF_W + 1
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [OP_WIDTH-1:0]     op_a,
  input  logic signed [OP_WIDTH-1:0]     op_b,
  output logic signed [2*OP_WIDTH-1:0]   prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= op_a * op_b;
    end
  end

endmodule

### rtl/zchng_gate_ctl.sv
// Per-channel crossing counters, polarity flags and gate levels of the noise gate.
// Depends on zchng_pkg for the command and status types.
module zchng_gate_ctl import zchng_pkg::*; #(
  parameter int COUNT_LIMIT         = COUNT_LIMIT_DEF,
  parameter int LEVEL_FRACTION_BITS = LEVEL_FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  gate_cmd_t        cmd,
  input  logic [REL_W-1:0] release_step,
  output gate_stat_t       stat
);

  localparam int CW   = $clog2(COUNT_LIMIT + 1);
  localparam int LW   = CW + LEVEL_FRACTION_BITS;
  localparam int MW   = (LW > REL_W) ? LW : REL_W;
  localparam int SH_L = (LEVEL_FRACTION_BITS < GATE_BITS) ? GATE_BITS - LEVEL_FRACTION_BITS : 0;
  localparam int SH_R = (LEVEL_FRACTION_BITS > GATE_BITS) ? LEVEL_FRACTION_BITS - GATE_BITS : 0;
  localparam int EW   = LEVEL_FRACTION_BITS + 1 + SH_L;
  localparam logic [CW-1:0] LIMIT     = CW'(COUNT_LIMIT);
  localparam logic [LW-1:0] LEVEL_ONE = LW'(1) << LEVEL_FRACTION_BITS;

  logic [CW-1:0] crossing_count [2];
  logic          was_negative [2];
  logic [LW-1:0] gate_level [2];

  logic [CW-1:0] cnt_cur;
  logic [CW-1:0] cnt_next;
  logic          neg_next;
  logic [LW-1:0] lvl_cur;
  logic [LW-1:0] lvl_next;
  logic [LW-1:0] target;
  logic [MW-1:0] lvl_ext;
  logic [MW-1:0] rel_ext;
  logic [LEVEL_FRACTION_BITS:0] lvl_clamp;
  logic [EW-1:0] g_wide;

  always_comb begin
    cnt_cur = crossing_count[cmd.ch];
    lvl_cur = gate_level[cmd.ch];
    if (cmd.x_pos) begin
      cnt_next = was_negative[cmd.ch] ? '0 : cnt_cur;
      neg_next = 1'b0;
    end else begin
      cnt_next = (cnt_cur >= LIMIT) ? LIMIT : cnt_cur + 1'b1;
      neg_next = 1'b1;
    end
    target  = {cnt_next, {LEVEL_FRACTION_BITS{1'b0}}};
    lvl_ext = MW'(lvl_cur);
    rel_ext = MW'(release_step);
    if (cmd.above) begin
      lvl_next = (lvl_cur < target) ? target : lvl_cur;
    end else begin
      lvl_next = (lvl_ext > rel_ext) ? LW'(lvl_ext - rel_ext) : '0;
    end
    lvl_clamp   = (lvl_cur >= LEVEL_ONE) ? LEVEL_ONE[LEVEL_FRACTION_BITS:0]
                                         : lvl_cur[LEVEL_FRACTION_BITS:0];
    g_wide      = (EW'(lvl_clamp) << SH_L) >> SH_R;
    stat.g      = g_wide[GATE_BITS:0];
    stat.closed = (lvl_cur == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        crossing_count[i] <= '0;
        was_negative[i]   <= 1'b0;
        gate_level[i]     <= '0;
      end
    end else if (cmd.upd) begin
      crossing_count[cmd.ch] <= cnt_next;
      was_negative[cmd.ch]   <= neg_next;
      gate_level[cmd.ch]     <= lvl_next;
    end
  end

endmodule

### rtl/zero_cross_hold_noise_gate.sv
// Top level of the stereo zero-crossing-hold noise gate: sequencer and datapath.
// Depends on zchng_pkg, zchng_gate_ctl and zchng_mul.
//
//   Port group   Direction  Handshake              Payload
//   cfg          in         cfg_write              cfg_index, cfg_data
//   in           in         in_valid / in_ready    left_sample, right_sample
//   out          out        out_valid / out_ready  left_out, right_out
//
// A word is accepted only in the idle state, so the next word waits until both channels are
// done and the result is in the output register. Each channel runs one load step, ten products
// on the shared multiplier, each a multiply step and a post-processing step, and a closed-gate test.
// The result waits in the output register while the next word is already accepted.
// Reset clears the channel state and sets the registers to their defaults.
module zero_cross_hold_noise_gate import zchng_pkg::*; #(
  parameter int SAMPLE_WIDTH        = SAMPLE_WIDTH_DEF,
  parameter int COUNT_LIMIT         = COUNT_LIMIT_DEF,
  parameter int LEVEL_FRACTION_BITS = LEVEL_FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [CFG_INDEX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] left_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] right_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] left_out,
  output logic signed [SAMPLE_WIDTH-1:0] right_out
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int SFRAC = SW - 1;
  localparam int OPW   = (SW + 1 > COEF_W + 1) ? SW + 1 : COEF_W + 1;
  localparam int PW    = 2 * OPW;
  localparam int YW    = SW + 1;
  localparam int Y3W   = YW + 2;
  localparam int ZW    = (Y3W > THR_W) ? Y3W : THR_W;
  localparam int MGW   = (SW > THR_W) ? SW : THR_W;
  localparam int OW    = PW - GATE_BITS;
  localparam logic signed [OW-1:0] O_MAX = OW'({SFRAC{1'b1}});
  localparam logic signed [OW-1:0] O_MIN = ~O_MAX;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_POST, ST_ZERO, ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_SQUARE = 4'd0, OP_H1 = 4'd1, OP_H2 = 4'd2, OP_H3 = 4'd3, OP_H4 = 4'd4,
    OP_SHAPE = 4'd5, OP_SOFT = 4'd6, OP_GATE = 4'd7, OP_WET = 4'd8, OP_DRY = 4'd9
  } op_t;

  state_t state;
  op_t    op;
  logic   ch;

  logic [THR_W-1:0] threshold_level;
  logic [REL_W-1:0] release_step;
  logic [WET_W-1:0] wet_mix;

  logic signed [SW-1:0] samp [2];
  logic signed [SW-1:0] res [2];
  logic signed [SW-1:0] x;
  logic [SW-1:0]        mag;
  logic                 xpos;
  logic [SW-1:0]        u;
  logic [COEF_W-1:0]    a;
  logic [SW-1:0]        s;
  logic signed [PW-1:0] acc;
  logic signed [YW-1:0] y;

  logic signed [SW-1:0]  cur_x;
  logic [SW-1:0]         cur_mag;
  gate_cmd_t             gcmd;
  gate_stat_t            gstat;
  logic [GATE_BITS:0]    gate_inv;
  logic signed [WET_W:0] dry;
  logic signed [OPW-1:0] ma;
  logic signed [OPW-1:0] mb;
  logic signed [PW-1:0]  prod;
  logic [COEF_W-1:0]     horner_sub;
  logic signed [PW-1:0]  sum;
  logic signed [OW-1:0]  o;
  logic signed [SW-1:0]  sat;
  logic signed [Y3W-1:0] y3;
  logic [Y3W-1:0]        y3_abs;
  logic                  horner_op;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cur_x        = samp[ch];
    cur_mag      = cur_x[SW-1] ? (~$unsigned(cur_x) + 1'b1) : $unsigned(cur_x);
    gcmd.upd     = (state == ST_LOAD);
    gcmd.ch      = ch;
    gcmd.x_pos   = !cur_x[SW-1] && (cur_x != '0);
    gcmd.above   = MGW'(cur_mag) > MGW'(threshold_level);
    gate_inv     = GATE_ONE - gstat.g;
    dry          = $signed({1'b0, MIX_ONE}) - $signed({1'b0, wet_mix});
    horner_op    = (op == OP_H1) || (op == OP_H2) || (op == OP_H3) || (op == OP_H4);
    horner_sub   = prod[SFRAC +: COEF_W];
    sum          = prod + acc;
    o            = sum[PW-1:GATE_BITS];
    if (o > O_MAX) begin
      sat = O_MAX[SW-1:0];
    end else if (o < O_MIN) begin
      sat = O_MIN[SW-1:0];
    end else begin
      sat = o[SW-1:0];
    end
    y3     = Y3W'(y) + (Y3W'(y) <<< 1);
    y3_abs = y3[Y3W-1] ? (~$unsigned(y3) + 1'b1) : $unsigned(y3);
  end

  always_comb begin
    case (op)
      OP_SQUARE: begin
        ma = $signed(OPW'(mag));
        mb = $signed(OPW'(mag));
      end
      OP_H1, OP_H2, OP_H3, OP_H4, OP_SHAPE: begin
        ma = $signed(OPW'(a));
        mb = $signed(OPW'(u));
      end
      OP_SOFT: begin
        ma = $signed(OPW'(s));
        mb = $signed(OPW'(gate_inv));
      end
      OP_GATE: begin
        ma = OPW'(x);
        mb = $signed(OPW'(gstat.g));
      end
      OP_WET: begin
        ma = OPW'(y);
        mb = $signed(OPW'(wet_mix));
      end
      OP_DRY: begin
        ma = OPW'(x);
        mb = OPW'(dry);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  zchng_gate_ctl #(
    .COUNT_LIMIT         (COUNT_LIMIT),
    .LEVEL_FRACTION_BITS (LEVEL_FRACTION_BITS)
  ) u_gate (
    .clk          (clk),
    .rst          (rst),
    .cmd          (gcmd),
    .release_step (release_step),
    .stat         (gstat)
  );

  zchng_mul #(
    .OP_WIDTH (OPW)
  ) u_mul (
    .clk  (clk),
    .en   (state == ST_MUL),
    .op_a (ma),
    .op_b (mb),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      op              <= OP_SQUARE;
      ch              <= 1'b0;
      out_valid       <= 1'b0;
      threshold_level <= THRESHOLD_RESET;
      release_step    <= RELEASE_RESET;
      wet_mix         <= WET_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_THRESHOLD: threshold_level <= cfg_data[THR_W-1:0];
          CFG_RELEASE:   release_step    <= cfg_data[REL_W-1:0];
          CFG_WET:       wet_mix         <= cfg_data[WET_W-1:0];
          default:       ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            samp[0] <= left_sample;
            samp[1] <= right_sample;
            ch      <= 1'b0;
            state   <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          x     <= cur_x;
          mag   <= cur_mag;
          xpos  <= gcmd.x_pos;
          a     <= shape_coef(3'd0);
          op    <= OP_SQUARE;
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_POST;
        end
        ST_POST: begin
          op    <= op_t'(op + 1'b1);
          state <= ST_MUL;
          case (op)
            OP_SQUARE: u <= prod[SFRAC +: SW];
            OP_H1, OP_H2, OP_H3, OP_H4: a <= shape_coef(op[2:0]) - horner_sub;
            OP_SHAPE:  s <= prod[COEF_W +: SW];
            OP_SOFT:   acc <= xpos ? prod : -prod;
            OP_GATE: begin
              y     <= sum[GATE_BITS +: YW];
              state <= ST_ZERO;
            end
            OP_WET:    acc <= prod;
            OP_DRY: begin
              res[ch] <= sat;
              if (ch) begin
                state <= ST_FINISH;
              end else begin
                ch    <= 1'b1;
                state <= ST_LOAD;
              end
            end
            default: ;
          endcase
        end
        ST_ZERO: begin
          if (gstat.closed && (ZW'(y3_abs) < ZW'(threshold_level))) begin
            y <= '0;
          end
          state <= ST_MUL;
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            left_out  <= res[0];
            right_out <= res[1];
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block still ready after accepting a word");

  a_horner_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POST && horner_op) |-> (shape_coef(op[2:0]) >= horner_sub))
    else $error("shape polynomial step went negative");

  a_gate_range: assert property (@(posedge clk) disable iff (rst)
    (gstat.g <= GATE_ONE) && (!gstat.closed || gstat.g == '0))
    else $error("gate value out of range or open while level is zero");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && (!out_valid || out_ready)) |=> (out_valid && in_ready))
    else $error("finished word not presented at the output");

endmodule

### tb/sv/zero_cross_hold_noise_gate_checker.sv
`timescale 1ns / 100ps
// Checker for the zero-crossing-hold noise gate: watches the register port and both word
// channels, predicts every gated stereo word and compares it with what the block delivers.
// Depends on zchng_pkg for the port widths, register indexes and reset values.
module zero_cross_hold_noise_gate_checker import zchng_pkg::*; (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [CFG_INDEX_W-1:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]               cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH_DEF-1:0]  left_sample,
  input  logic signed [SAMPLE_WIDTH_DEF-1:0]  right_sample,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [SAMPLE_WIDTH_DEF-1:0]  left_out,
  input  logic signed [SAMPLE_WIDTH_DEF-1:0]  right_out,
  output int                                  words_due,
  output int                                  mismatches
);

  localparam int SW    = SAMPLE_WIDTH_DEF;
  localparam int CNT_W = 13;
  localparam int LVL_W = 29;
  localparam longint UNITY = 65536;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } gated_pair_t;

  gated_pair_t gated_words_due[$];

  logic [THR_W-1:0] threshold;
  logic [REL_W-1:0] rel_step;
  logic [WET_W-1:0] wet;
  logic [CNT_W-1:0] cross_count [2];
  logic             was_neg [2];
  logic [LVL_W-1:0] gate_lvl [2];
  int               fails = 0;

  assign mismatches = fails;

  function automatic longint cos_shape(input longint t);
    longint u;
    longint a;
    u = (t * t) >>> (SW - 1);
    a = 296;
    a = 26631 - ((a * u) >>> (SW - 1));
    a = 1491308 - ((a * u) >>> (SW - 1));
    a = 44739243 - ((a * u) >>> (SW - 1));
    a = 536870912 - ((a * u) >>> (SW - 1));
    return (a * u) >>> 30;
  endfunction

  function automatic logic signed [SW-1:0] gate_sample(input int ch,
                                                       input logic signed [SW-1:0] smp);
    longint x;
    longint mag;
    longint lvl;
    longint tgt;
    longint g;
    longint s;
    longint y;
    longint y3;
    longint o;
    longint thr;
    longint wt;
    longint lim;
    int     c;
    x   = longint'(smp);
    mag = (x < 0) ? -x : x;
    thr = longint'(threshold);
    wt  = longint'(wet);
    lim = longint'(1) << (SW - 1);
    if (x > 0) begin
      if (was_neg[ch]) cross_count[ch] = '0;
      was_neg[ch] = 1'b0;
    end else begin
      c = cross_count[ch] + 1;
      cross_count[ch] = (c > COUNT_LIMIT_DEF) ? CNT_W'(COUNT_LIMIT_DEF) : CNT_W'(c);
      was_neg[ch] = 1'b1;
    end
    lvl = longint'(gate_lvl[ch]);
    if (mag > thr) begin
      tgt = longint'(cross_count[ch]) << LEVEL_FRACTION_BITS_DEF;
      if (lvl < tgt) lvl = tgt;
    end else begin
      lvl = (lvl > longint'(rel_step)) ? lvl - longint'(rel_step) : 0;
    end
    gate_lvl[ch] = LVL_W'(lvl);
    g = (lvl >= UNITY) ? UNITY : lvl;
    s = cos_shape(mag) * (UNITY - g);
    if (x > 0) y = (x * g + s) >>> GATE_BITS;
    else       y = (x * g - s) >>> GATE_BITS;
    if (lvl == 0) begin
      y3 = y * 3;
      if (y3 < 0) y3 = -y3;
      if (y3 < thr) y = 0;
    end
    o = (y * wt + x * (UNITY - wt)) >>> 16;
    if (o > lim - 1) o = lim - 1;
    if (o < -lim) o = -lim;
    return SW'(o);
  endfunction

  always @(posedge clk) begin
    gated_pair_t due;
    if (rst) begin
      threshold = THRESHOLD_RESET;
      rel_step  = RELEASE_RESET;
      wet       = WET_RESET;
      for (int i = 0; i < 2; i++) begin
        cross_count[i] = '0;
        was_neg[i]     = 1'b0;
        gate_lvl[i]    = '0;
      end
      gated_words_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_THRESHOLD: threshold = cfg_data[THR_W-1:0];
          CFG_RELEASE:   rel_step  = cfg_data[REL_W-1:0];
          CFG_WET:       wet       = cfg_data[WET_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (gated_words_due.size() == 0) begin
          $display("%0t: word with nothing expected, got left_out %0d right_out %0d",
                   $time, left_out, right_out);
          fails++;
        end else begin
          due = gated_words_due.pop_front();
          if (left_out !== due.left) begin
            $display("%0t: left_out expected %0d, got %0d", $time, due.left, left_out);
            fails++;
          end
          if (right_out !== due.right) begin
            $display("%0t: right_out expected %0d, got %0d", $time, due.right, right_out);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        due.left  = gate_sample(0, left_sample);
        due.right = gate_sample(1, right_sample);
        gated_words_due.push_back(due);
      end
    end
    words_due <= gated_words_due.size();
  end

endmodule

### tb/sv/zero_cross_hold_noise_gate_test.sv
`timescale 1ns / 100ps
// Top of the noise gate testbench: clock, reset, register settings, stereo words and the verdict.
// Depends on zchng_pkg, zero_cross_hold_noise_gate and zero_cross_hold_noise_gate_checker.
module zero_cross_hold_noise_gate_test;
  import zchng_pkg::*;

  localparam int SW            = SAMPLE_WIDTH_DEF;
  localparam int IDLE_MAX      = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE        = 60;
  localparam int DIRECTED_N    = 22;
  localparam int COUNT_RUN     = 20;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 100;
  localparam int FULL_SCALE    = 8388607;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {
    BURST_QUIET,
    BURST_BUILD,
    BURST_LOUD,
    BURST_NOISE,
    BURST_EXTREME
  } burst_t;

  logic                   clk;
  logic                   rst          = 1'b1;
  logic                   cfg_write    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   in_valid     = 1'b0;
  logic                   in_ready;
  logic signed [SW-1:0]   left_sample  = '0;
  logic signed [SW-1:0]   right_sample = '0;
  logic                   out_valid;
  logic                   out_ready    = 1'b0;
  logic signed [SW-1:0]   left_out;
  logic signed [SW-1:0]   right_out;

  int     words_due;
  int     mismatches;
  int     quiet_cycles = 0;
  int     cur_thr      = THRESHOLD_RESET;
  bit     idle_on      = 1'b1;
  bit     hold_out     = 1'b0;
  burst_t burst_kind [2];
  int     burst_len [2] = '{0, 0};
  logic signed [SW-1:0] directed_words [DIRECTED_N];

  zero_cross_hold_noise_gate i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_out     (left_out),
    .right_out    (right_out)
  );

  zero_cross_hold_noise_gate_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_out     (left_out),
    .right_out    (right_out),
    .words_due    (words_due),
    .mismatches   (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: a random stall before each word while idle_on is set, and one long hold-off on request.
  initial begin
    int stall;
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        stall = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_gate(input int thr, input int rel, input int wet_val);
    logic [CFG_DATA_W-1:0] d;
    write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
    d = CFG_DATA_W'($urandom);
    d[REL_W-1:0] = REL_W'(rel);
    write_reg(CFG_RELEASE, d);
    d = CFG_DATA_W'($urandom);
    d[WET_W-1:0] = WET_W'(wet_val);
    write_reg(CFG_WET, d);
    cur_thr = thr;
  endtask

  task automatic send_pair(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r);
    int gap;
    gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    left_sample  <= l;
    right_sample <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Each channel runs in bursts so that gates open, hold and release in realistic patterns.
  function automatic logic signed [SW-1:0] next_sample(input int ch);
    longint v;
    longint m;
    int     pick;
    if (burst_len[ch] == 0) begin
      burst_kind[ch] = burst_t'($urandom_range(0, 4));
      burst_len[ch]  = $urandom_range(1, 40);
    end
    burst_len[ch]--;
    case (burst_kind[ch])
      BURST_QUIET: v = longint'($urandom_range(0, 2 * cur_thr + 8)) - cur_thr - 4;
      BURST_BUILD: v = ($urandom_range(0, 3) == 0) ? 0 : -longint'($urandom_range(0, cur_thr));
      BURST_LOUD: begin
        m = longint'($urandom_range(cur_thr + 1, FULL_SCALE + 1));
        v = ($urandom_range(0, 1) && m <= FULL_SCALE) ? m : -m;
      end
      BURST_NOISE: v = longint'($signed(SW'($urandom)));
      default: begin
        pick = $urandom_range(0, 4);
        case (pick)
          0:       v = FULL_SCALE;
          1:       v = -FULL_SCALE - 1;
          2:       v = 1;
          3:       v = -1;
          default: v = 0;
        endcase
      end
    endcase
    if (v > FULL_SCALE) v = FULL_SCALE;
    if (v < -FULL_SCALE - 1) v = -FULL_SCALE - 1;
    return SW'(v);
  endfunction

  initial begin
    int thr;
    int rel;
    int wet_val;
    directed_words = '{0, 0, -8388608, 8388607, 1510, 1511, -1511, -1510, 1, -1, 100,
                       -100, 0, 8388607, -8388608, 4194304, -4194304, 3000, -3000, 0,
                       2, 8388607};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));

    for (int i = 0; i < DIRECTED_N; i++)
      send_pair(directed_words[i], directed_words[DIRECTED_N-1-i]);
    drain();

    // A quiet negative run builds up the crossing count, then one full-scale word
    // opens the left gate and a longer quiet stretch lets it release completely.
    idle_on = 1'b0;
    set_gate(THRESHOLD_RESET, 65535, MIX_ONE);
    for (int i = 0; i < COUNT_RUN; i++) send_pair(SW'(-1), next_sample(1));
    send_pair(SW'(-FULL_SCALE - 1), next_sample(1));
    for (int i = 0; i < 2 * COUNT_RUN; i++) send_pair(SW'(5), next_sample(1));
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_gate(0, 0, MIX_ONE);
        1: set_gate(FULL_SCALE, 65535, 0);
        2: set_gate(THRESHOLD_RESET, 1, 131071);
        3: set_gate(1, 65535, MIX_ONE);
        default: begin
          thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, FULL_SCALE)
                                            : $urandom_range(0, 20000);
          rel = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 4000);
          case ($urandom_range(0, 2))
            0:       wet_val = MIX_ONE;
            1:       wet_val = $urandom_range(0, MIX_ONE);
            default: wet_val = $urandom_range(0, 131071);
          endcase
          set_gate(thr, rel, wet_val);
          if ($urandom_range(0, 1)) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        end
      endcase
      idle_on = (p % 3 != 2);
      if (p == 5) hold_out = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_pair(next_sample(0), next_sample(1));
      drain();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
